>>> hw/rtl/round_robin_thread_scheduler_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the round-robin thread scheduler
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_CORE_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_CORE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RRTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen outside reset.
`define RRTS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> hw/rtl/rrts_pkg.sv
// ---------------------------------------------------------------------------
// rrts_pkg
// Types and codes shared by the round-robin thread scheduler files.
// ---------------------------------------------------------------------------
package rrts_pkg;

  localparam int unsigned ThreadW = 4;
  localparam int unsigned OpW     = 3;
  localparam int unsigned StatusW = 2;

  typedef logic [ThreadW-1:0] thread_t;

  localparam thread_t IdleReset = 4'd15;

  typedef enum logic [OpW-1:0] {
    OP_TICK    = 3'd0,
    OP_ENQUEUE = 3'd1,
    OP_DEQUEUE = 3'd2,
    OP_WAKE    = 3'd3,
    OP_SUSPEND = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

endpackage

>>> hw/rtl/rrts_in_if.sv
// ---------------------------------------------------------------------------
// rrts_in_if
// Operation channel: valid/ready handshake with opcode and thread number.
// ---------------------------------------------------------------------------
interface rrts_in_if;
  logic                          valid;
  logic                          ready;
  logic [rrts_pkg::OpW-1:0]      opcode;
  logic [rrts_pkg::ThreadW-1:0]  thread_id;

  modport source (output valid, output opcode, output thread_id, input ready);
  modport sink   (input valid, input opcode, input thread_id, output ready);
endinterface

>>> hw/rtl/rrts_out_if.sv
// ---------------------------------------------------------------------------
// rrts_out_if
// Result channel: valid/ready handshake with the scheduler state after an op.
// ---------------------------------------------------------------------------
interface rrts_out_if #(
  parameter int unsigned CNT_W = 5
);
  logic                          valid;
  logic                          ready;
  logic [rrts_pkg::ThreadW-1:0]  running_id;
  logic                          is_idle;
  logic [CNT_W-1:0]              queue_count;
  logic [rrts_pkg::StatusW-1:0]  status;

  modport source (output valid, output running_id, output is_idle,
                  output queue_count, output status, input ready);
  modport sink   (input valid, input running_id, input is_idle,
                  input queue_count, input status, output ready);
endinterface

>>> hw/rtl/rrts_ram.sv
// ---------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module rrts_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/round_robin_thread_scheduler_core.sv
// ---------------------------------------------------------------------------
// round_robin_thread_scheduler_core
// Path from accept to result: enqueue, wake, suspend and unused opcodes pass
//   through S_EXEC and S_FIN; a tick adds S_TK_RD, then S_TK_WAIT unless the
//   queue is empty; dequeue loops S_DQ_RD and S_DQ_CHK to find the thread, then
//   moves later entries one place toward the head through the queue RAM ports.
// One operation at a time; the next is accepted the cycle after the result is
//   parked in the output register. Reset clears head, count and all suspended
//   marks, and sets the running and idle thread to 15; queue RAM is not cleared.
// ---------------------------------------------------------------------------
`include "round_robin_thread_scheduler_core_macros.svh"

module round_robin_thread_scheduler_core #(
  parameter int unsigned MAX_THREADS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         idle_id_we_i,
  input  logic [rrts_pkg::ThreadW-1:0] idle_id_i,
  rrts_in_if.sink                      in_i,
  rrts_out_if.source                   out_o
);

  localparam int unsigned IdxW = $clog2(MAX_THREADS);
  localparam int unsigned CntW = $clog2(MAX_THREADS + 1);
  localparam int unsigned TW   = rrts_pkg::ThreadW;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_EXEC    = 7'b0000010,
    S_TK_RD   = 7'b0000100,
    S_TK_WAIT = 7'b0001000,
    S_DQ_RD   = 7'b0010000,
    S_DQ_CHK  = 7'b0100000,
    S_FIN     = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  rrts_pkg::op_e       op_q, op_d;
  rrts_pkg::thread_t   tid_q, tid_d;
  rrts_pkg::thread_t   run_q, run_d;
  rrts_pkg::thread_t   idle_q;
  rrts_pkg::status_e   st_q, st_d;
  logic [IdxW-1:0]     head_q, head_d;
  logic [CntW-1:0]     len_q, len_d;
  logic [CntW-1:0]     p_q, p_d;
  logic                found_q, found_d;
  logic [MAX_THREADS-1:0] susp_q;

  logic                mark_we;
  rrts_pkg::thread_t   mark_tid;
  logic                mark_val;

  logic                ram_we;
  logic [CntW-1:0]     w_off, r_off;
  rrts_pkg::thread_t   ram_wdata, ram_rdata;
  logic [IdxW-1:0]     ram_waddr, ram_raddr;

  logic                out_load;
  logic                out_valid_q;
  rrts_pkg::thread_t   out_run_q;
  logic                out_idle_q;
  logic [CntW-1:0]     out_cnt_q;
  rrts_pkg::status_e   out_st_q;

  logic                full;

  // Queue position to RAM address; head + off stays below twice the depth.
  function automatic logic [IdxW-1:0] slot(input logic [IdxW-1:0] head,
                                           input logic [CntW-1:0] off);
    logic [CntW:0] sum;
    sum = (CntW+1)'(head) + (CntW+1)'(off);
    if (sum >= (CntW+1)'(MAX_THREADS)) begin
      sum = sum - (CntW+1)'(MAX_THREADS);
    end
    return sum[IdxW-1:0];
  endfunction

  function automatic logic mark_ok(input rrts_pkg::thread_t t);
    return 32'(t) < 32'(MAX_THREADS);
  endfunction

  function automatic logic [IdxW-1:0] mark_idx(input rrts_pkg::thread_t t);
    logic [TW+IdxW-1:0] ext;
    ext = {{IdxW{1'b0}}, t};
    return ext[IdxW-1:0];
  endfunction

  function automatic logic is_susp(input logic [MAX_THREADS-1:0] marks,
                                   input rrts_pkg::thread_t t);
    return mark_ok(t) && marks[mark_idx(t)];
  endfunction

  assign full      = (len_q == CntW'(MAX_THREADS));
  assign ram_waddr = slot(head_q, w_off);
  assign ram_raddr = slot(head_q, r_off);
  assign in_i.ready = (state_q == S_IDLE);

  rrts_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_THREADS)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    tid_d     = tid_q;
    run_d     = run_q;
    st_d      = st_q;
    head_d    = head_q;
    len_d     = len_q;
    p_d       = p_q;
    found_d   = found_q;
    mark_we   = 1'b0;
    mark_tid  = tid_q;
    mark_val  = 1'b0;
    ram_we    = 1'b0;
    w_off     = len_q;
    ram_wdata = tid_q;
    r_off     = p_q;
    out_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d    = rrts_pkg::op_e'(in_i.opcode);
          tid_d   = in_i.thread_id;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        st_d    = rrts_pkg::ST_OK;
        state_d = S_FIN;
        unique case (op_q) inside
          rrts_pkg::OP_TICK: begin
            // requeue the running thread at the tail if it is still ready and not the idle thread
            if (!is_susp(susp_q, run_q) && run_q != idle_q) begin
              if (full) begin
                st_d = rrts_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = run_q;
                len_d     = len_q + 1'b1;
              end
            end
            state_d = S_TK_RD;
          end
          rrts_pkg::OP_ENQUEUE, rrts_pkg::OP_WAKE: begin
            if (op_q == rrts_pkg::OP_WAKE) begin
              mark_we = 1'b1;
            end
            if (full) begin
              st_d = rrts_pkg::ST_FULL;
            end else begin
              ram_we = 1'b1;
              len_d  = len_q + 1'b1;
            end
          end
          rrts_pkg::OP_DEQUEUE: begin
            p_d     = '0;
            found_d = 1'b0;
            state_d = S_DQ_RD;
          end
          rrts_pkg::OP_SUSPEND: begin
            mark_we  = 1'b1;
            mark_val = 1'b1;
          end
          default: ;
        endcase
      end
      S_TK_RD: begin
        if (len_q == '0) begin
          run_d    = idle_q;
          mark_we  = 1'b1;
          mark_tid = idle_q;
          state_d  = S_FIN;
        end else begin
          r_off   = '0;
          state_d = S_TK_WAIT;
        end
      end
      S_TK_WAIT: begin
        run_d    = ram_rdata;
        mark_we  = 1'b1;
        mark_tid = ram_rdata;
        head_d   = slot(head_q, CntW'(1));
        len_d    = len_q - 1'b1;
        state_d  = S_FIN;
      end
      S_DQ_RD: begin
        if (!found_q) begin
          if (p_q == len_q) begin
            st_d    = rrts_pkg::ST_MISSING;
            state_d = S_FIN;
          end else begin
            r_off   = p_q;
            state_d = S_DQ_CHK;
          end
        end else if (p_q + 1'b1 == len_q) begin
          len_d   = len_q - 1'b1;
          state_d = S_FIN;
        end else begin
          r_off   = p_q + 1'b1;
          state_d = S_DQ_CHK;
        end
      end
      S_DQ_CHK: begin
        if (!found_q) begin
          if (ram_rdata == tid_q) begin
            found_d = 1'b1;
          end else begin
            p_d = p_q + 1'b1;
          end
        end else begin
          // close the gap: move the next entry one place toward the head
          ram_we    = 1'b1;
          w_off     = p_q;
          ram_wdata = ram_rdata;
          p_d       = p_q + 1'b1;
        end
        state_d = S_DQ_RD;
      end
      S_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_q       <= rrts_pkg::IdleReset;
      idle_q      <= rrts_pkg::IdleReset;
      head_q      <= '0;
      len_q       <= '0;
      susp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      run_q   <= run_d;
      head_q  <= head_d;
      len_q   <= len_d;
      if (idle_id_we_i) begin
        idle_q <= idle_id_i;
      end
      if (mark_we && mark_ok(mark_tid)) begin
        susp_q[mark_idx(mark_tid)] <= mark_val;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    tid_q   <= tid_d;
    st_q    <= st_d;
    p_q     <= p_d;
    found_q <= found_d;
    if (out_load) begin
      out_run_q  <= run_q;
      out_idle_q <= (run_q == idle_q);
      out_cnt_q  <= len_q;
      out_st_q   <= st_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.running_id  = out_run_q;
  assign out_o.is_idle     = out_idle_q;
  assign out_o.queue_count = out_cnt_q;
  assign out_o.status      = out_st_q;

  `RRTS_ASSERT(a_accept_to_exec,
               (in_i.valid && in_i.ready) |=> (state_q == S_EXEC),
               "accepted transaction did not start")
  `RRTS_ASSERT(a_fin_holds,
               (state_q == S_FIN && out_valid_q && !out_o.ready) |=> (state_q == S_FIN),
               "result dropped while output stalled")
  `RRTS_ASSERT(a_dq_ptr,
               (state_q == S_DQ_RD) |-> (p_q <= len_q),
               "dequeue pointer past queue length")
  `RRTS_ASSERT_NEVER(a_len_bound,
                     len_q > CntW'(MAX_THREADS),
                     "queue length above depth")

endmodule
